### rtl/geohash_stream_decoder_defines.svh
// Assertion macros used by the back end of the geohash stream decoder RTL.
`ifndef GEOHASH_STREAM_DECODER_DEFINES_SVH
`define GEOHASH_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on aclk and disabled while aresetn is low.
`define GSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled while aresetn is low.
`define GSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gsd_pkg.sv
// Shared constants and types of the geohash stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package gsd_pkg;

    // Longest text that is decoded; longer text reports a length error.
    localparam int GSD_MAX_LEN = 12;
    // The digit count saturates here, one past the longest legal text.
    localparam int GSD_COUNT_SAT = 13;
    // Bits kept per axis accumulator.
    localparam int GSD_ACC_W = 30;
    // Default number of entries in the queue between front and back.
    localparam int GSD_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        GSD_OK       = 2'd0,
        GSD_BAD_LEN  = 2'd1,
        GSD_BAD_CHAR = 2'd2
    } gsd_status_t;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic       is_space;
        logic       is_digit;
        logic [4:0] digit;
        logic       last;
    } gsd_word_t;

endpackage

`default_nettype wire

### rtl/gsd_front.sv
// Front end: accepts characters, classifies them and registers the result.
`timescale 1ns / 1ps
`default_nettype none

module gsd_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_char_code,
    input  wire logic              s_last_char,
    output logic                   f_valid,
    input  wire logic              f_ready,
    output gsd_pkg::gsd_word_t     f_word
);
    import gsd_pkg::*;

    // Base-32 alphabet, first character in the top byte.
    localparam logic [255:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    logic      valid_reg;
    gsd_word_t word_reg;
    gsd_word_t word_next;
    logic [7:0] lower;
    logic       take;

    // Fold upper case onto lower case, then search the alphabet.
    always_comb begin
        lower = s_char_code;
        if (s_char_code >= 8'h41 && s_char_code <= 8'h5A) begin
            lower = s_char_code + 8'h20;
        end
        word_next.is_space = (s_char_code >= 8'h09 && s_char_code <= 8'h0D)
                             || (s_char_code == 8'h20);
        word_next.is_digit = 1'b0;
        word_next.digit    = 5'd0;
        word_next.last     = s_last_char;
        for (int i = 0; i < 32; i++) begin
            if (ALPHABET[255 - 8 * i -: 8] == lower) begin
                word_next.is_digit = 1'b1;
                word_next.digit    = 5'(i);
            end
        end
    end

    // The stage takes a new word when it is empty or its word moves on.
    assign s_ready = !valid_reg || f_ready;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            word_reg <= word_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_word  = word_reg;

endmodule

`default_nettype wire

### rtl/gsd_queue.sv
// Small queue of classified words between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none

module gsd_queue #(
    parameter int Depth = gsd_pkg::GSD_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gsd_pkg::gsd_word_t in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gsd_pkg::gsd_word_t      out_word
);
    import gsd_pkg::*;

    // User keeps Depth a power of two, at least two (unenforced): pointers wrap.
    localparam int PTR_W = $clog2(Depth);
    localparam int CNT_W = $clog2(Depth + 1);

    gsd_word_t          entry_reg [Depth];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != CNT_W'(Depth));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_word  = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

`default_nettype wire

### rtl/gsd_back.sv
// Back end: accumulates digit bits and builds the result on the last word.
`timescale 1ns / 1ps
`default_nettype none
`include "geohash_stream_decoder_defines.svh"

module gsd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire gsd_pkg::gsd_word_t q_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [3:0]              m_digit_count,
    output logic signed [31:0]      m_lat_low,
    output logic signed [31:0]      m_lat_high,
    output logic signed [32:0]      m_lon_low,
    output logic signed [32:0]      m_lon_high,
    output logic signed [31:0]      m_lat_center,
    output logic signed [32:0]      m_lon_center,
    output logic [30:0]             m_lat_half_size,
    output logic [31:0]             m_lon_half_size
);
    import gsd_pkg::*;

    localparam int          ACC_W     = GSD_ACC_W;
    localparam logic [3:0]  MAX_LEN   = 4'(GSD_MAX_LEN);
    localparam logic [3:0]  COUNT_SAT = 4'(GSD_COUNT_SAT);

    // Accumulator state.
    logic [ACC_W-1:0] lat_bits_reg, lat_bits_next;
    logic [ACC_W-1:0] lon_bits_reg, lon_bits_next;
    logic [3:0]       digits_seen_reg, digits_seen_next;
    logic             bad_char_reg, bad_char_next;

    // Output register.
    logic               m_valid_reg;
    gsd_status_t        status_reg, status_next;
    logic [3:0]         count_reg;
    logic signed [31:0] lat_low_reg, lat_low_next;
    logic signed [31:0] lat_high_reg, lat_high_next;
    logic signed [32:0] lon_low_reg, lon_low_next;
    logic signed [32:0] lon_high_reg, lon_high_next;
    logic signed [31:0] lat_center_reg, lat_center_next;
    logic signed [32:0] lon_center_reg, lon_center_next;
    logic [30:0]        lat_half_reg, lat_half_next;
    logic [31:0]        lon_half_reg, lon_half_next;

    logic        out_free;
    logic        pop;
    logic [6:0]  five_n;
    logic [6:0]  five_n_up;
    logic [5:0]  lat_n;
    logic [5:0]  lon_n;
    logic [5:0]  lat_shift;
    logic [5:0]  lon_shift;
    logic [30:0] lat_aligned;
    logic [31:0] lon_aligned;
    logic [30:0] lat_half;
    logic [31:0] lon_half;
    logic signed [31:0] lat_low;
    logic signed [32:0] lon_low;

    // A last word waits until the output register is free; others go at once.
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = !q_word.last || out_free;
    assign pop      = q_valid && q_ready;

    // Count the character and split the digit bits over the two axes.
    // Even digits give longitude three bits, odd digits give latitude three.
    always_comb begin
        lat_bits_next    = lat_bits_reg;
        lon_bits_next    = lon_bits_reg;
        digits_seen_next = digits_seen_reg;
        bad_char_next    = bad_char_reg;
        if (!q_word.is_space) begin
            if (digits_seen_reg < COUNT_SAT) begin
                digits_seen_next = digits_seen_reg + 4'd1;
            end
            if (digits_seen_reg < MAX_LEN) begin
                if (!q_word.is_digit) begin
                    bad_char_next = 1'b1;
                end else if (!digits_seen_reg[0]) begin
                    lon_bits_next = {lon_bits_reg[ACC_W-4:0],
                                     q_word.digit[4], q_word.digit[2], q_word.digit[0]};
                    lat_bits_next = {lat_bits_reg[ACC_W-3:0],
                                     q_word.digit[3], q_word.digit[1]};
                end else begin
                    lon_bits_next = {lon_bits_reg[ACC_W-3:0],
                                     q_word.digit[3], q_word.digit[1]};
                    lat_bits_next = {lat_bits_reg[ACC_W-4:0],
                                     q_word.digit[4], q_word.digit[2], q_word.digit[0]};
                end
            end
        end
    end

    // Bit counts per axis: latitude gets 5n/2 bits, longitude (5n+1)/2.
    assign five_n    = {1'b0, digits_seen_next, 2'b00} + 7'(digits_seen_next);
    assign five_n_up = five_n + 7'd1;
    assign lat_n     = five_n[6:1];
    assign lon_n     = five_n_up[6:1];
    assign lat_shift = 6'd31 - lat_n;
    assign lon_shift = 6'd32 - lon_n;

    // Left-align the accumulated bits to get the offset of the low edge.
    assign lat_aligned = 31'(lat_bits_next) << lat_shift;
    assign lon_aligned = 32'(lon_bits_next) << lon_shift;
    assign lat_half    = 31'h4000_0000 >> lat_n;
    assign lon_half    = 32'h8000_0000 >> lon_n;
    assign lat_low     = $signed({1'b0, lat_aligned}) - 32'sh4000_0000;
    assign lon_low     = $signed({1'b0, lon_aligned}) - 33'sh0_8000_0000;

    // Status and cell geometry; any error clears the geometry.
    always_comb begin
        if (digits_seen_next == 4'd0 || digits_seen_next > MAX_LEN) begin
            status_next = GSD_BAD_LEN;
        end else if (bad_char_next) begin
            status_next = GSD_BAD_CHAR;
        end else begin
            status_next = GSD_OK;
        end
        if (status_next == GSD_OK) begin
            lat_low_next    = lat_low;
            lat_high_next   = lat_low + $signed({lat_half, 1'b0});
            lat_center_next = lat_low + $signed({1'b0, lat_half});
            lon_low_next    = lon_low;
            lon_high_next   = lon_low + $signed({lon_half, 1'b0});
            lon_center_next = lon_low + $signed({1'b0, lon_half});
            lat_half_next   = lat_half;
            lon_half_next   = lon_half;
        end else begin
            lat_low_next    = '0;
            lat_high_next   = '0;
            lat_center_next = '0;
            lon_low_next    = '0;
            lon_high_next   = '0;
            lon_center_next = '0;
            lat_half_next   = '0;
            lon_half_next   = '0;
        end
    end

    // Accumulators restart after every last word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_bits_reg    <= '0;
            lon_bits_reg    <= '0;
            digits_seen_reg <= '0;
            bad_char_reg    <= 1'b0;
        end else if (pop) begin
            if (q_word.last) begin
                lat_bits_reg    <= '0;
                lon_bits_reg    <= '0;
                digits_seen_reg <= '0;
                bad_char_reg    <= 1'b0;
            end else begin
                lat_bits_reg    <= lat_bits_next;
                lon_bits_reg    <= lon_bits_next;
                digits_seen_reg <= digits_seen_next;
                bad_char_reg    <= bad_char_next;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && q_word.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (pop && q_word.last) begin
            status_reg     <= status_next;
            count_reg      <= digits_seen_next;
            lat_low_reg    <= lat_low_next;
            lat_high_reg   <= lat_high_next;
            lon_low_reg    <= lon_low_next;
            lon_high_reg   <= lon_high_next;
            lat_center_reg <= lat_center_next;
            lon_center_reg <= lon_center_next;
            lat_half_reg   <= lat_half_next;
            lon_half_reg   <= lon_half_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_digit_count   = count_reg;
    assign m_lat_low       = lat_low_reg;
    assign m_lat_high      = lat_high_reg;
    assign m_lon_low       = lon_low_reg;
    assign m_lon_high      = lon_high_reg;
    assign m_lat_center    = lat_center_reg;
    assign m_lon_center    = lon_center_reg;
    assign m_lat_half_size = lat_half_reg;
    assign m_lon_half_size = lon_half_reg;

    // A finished text leaves the accumulators clear for the next one.
    `GSD_ASSERT_NEXT(a_clear_after_last, pop && q_word.last, digits_seen_reg == 4'd0 && lat_bits_reg == '0 && lon_bits_reg == '0 && !bad_char_reg, "accumulators not cleared after last word")
    // An error result carries no cell size.
    `GSD_ASSERT_IMPL(a_error_zero_size, m_valid_reg && status_reg != GSD_OK, lat_half_reg == '0 && lon_half_reg == '0, "error result with nonzero cell size")
    // A good result has its edges one full cell apart on both axes.
    `GSD_ASSERT_IMPL(a_ok_cell_span, m_valid_reg && status_reg == GSD_OK, (lat_high_reg - lat_low_reg == $signed(32'(lat_half_reg) << 1)) && (lon_high_reg - lon_low_reg == $signed(33'(lon_half_reg) << 1)), "cell edges do not match cell size")

endmodule

`default_nettype wire

### rtl/geohash_stream_decoder.sv
// Top level of the geohash stream decoder: front end, queue and back end.
`timescale 1ns / 1ps
`default_nettype none

// Decodes geohash text streamed one ASCII byte per word, with s_last_char on
// the final byte, into one result word: status, digit count, bounding box,
// centre and half sizes in fixed point (latitude 2^31 units per 180 degrees,
// longitude 2^32 units per 360 degrees). The block takes one byte per clock
// cycle, sustained, while s_ready is high; it drops when the queue fills
// behind a result held by m_ready. The last byte goes through the front
// register and a queue entry before the back end's output register loads
// the result. The queue between front and back holds QueueDepth words, which
// the user keeps a power of two, at least two (unchecked by the block), so
// either side may stall without stopping the other; no memory, no clearing pass.
module geohash_stream_decoder #(
    parameter int QueueDepth = gsd_pkg::GSD_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_code,
    input  wire logic               s_last_char,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [3:0]              m_digit_count,
    output logic signed [31:0]      m_lat_low,
    output logic signed [31:0]      m_lat_high,
    output logic signed [32:0]      m_lon_low,
    output logic signed [32:0]      m_lon_high,
    output logic signed [31:0]      m_lat_center,
    output logic signed [32:0]      m_lon_center,
    output logic [30:0]             m_lat_half_size,
    output logic [31:0]             m_lon_half_size
);
    import gsd_pkg::*;

    logic      f_valid;
    logic      f_ready;
    gsd_word_t f_word;
    logic      q_valid;
    logic      q_ready;
    gsd_word_t q_word;

    // Classify each byte as whitespace, digit or invalid.
    gsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_word      (f_word)
    );

    // Decouple the front end from the back end.
    gsd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_word  (q_word)
    );

    // Accumulate bits and produce the result.
    gsd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_word          (q_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_digit_count   (m_digit_count),
        .m_lat_low       (m_lat_low),
        .m_lat_high      (m_lat_high),
        .m_lon_low       (m_lon_low),
        .m_lon_high      (m_lon_high),
        .m_lat_center    (m_lat_center),
        .m_lon_center    (m_lon_center),
        .m_lat_half_size (m_lat_half_size),
        .m_lon_half_size (m_lon_half_size)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the geohash stream decoder with its own cell predictor.
`timescale 1ns / 1ps

module testbench;
    import gsd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam string DIGIT_SET = "0123456789bcdefghjkmnpqrstuvwxyz";

    typedef logic [7:0] text_t[$];

    // One expected result word: the decoded cell or an error.
    typedef struct {
        gsd_status_t        status;
        logic [3:0]         count;
        logic signed [31:0] lat_lo;
        logic signed [31:0] lat_hi;
        logic signed [32:0] lon_lo;
        logic signed [32:0] lon_hi;
        logic signed [31:0] lat_mid;
        logic signed [32:0] lon_mid;
        logic [30:0]        lat_half;
        logic [31:0]        lon_half;
    } cell_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [7:0] s_char_code;
    logic s_last_char;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_status;
    logic [3:0] m_digit_count;
    logic signed [31:0] m_lat_low;
    logic signed [31:0] m_lat_high;
    logic signed [32:0] m_lon_low;
    logic signed [32:0] m_lon_high;
    logic signed [31:0] m_lat_center;
    logic signed [32:0] m_lon_center;
    logic [30:0] m_lat_half_size;
    logic [31:0] m_lon_half_size;

    // Predictor state: accumulated axis bits, digit count and the bad digit flag.
    logic [29:0] lat_acc;
    logic [29:0] lon_acc;
    logic [3:0] seen_count;
    logic bad_seen;

    cell_t pending_cells[$];
    int mismatches;
    int chars_sent;
    int cycle_count;
    bit sender_idle;
    bit stall_enable;
    bit hold_request;

    geohash_stream_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_last_char     (s_last_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_digit_count   (m_digit_count),
        .m_lat_low       (m_lat_low),
        .m_lat_high      (m_lat_high),
        .m_lon_low       (m_lon_low),
        .m_lon_high      (m_lon_high),
        .m_lat_center    (m_lat_center),
        .m_lon_center    (m_lon_center),
        .m_lat_half_size (m_lat_half_size),
        .m_lon_half_size (m_lon_half_size)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a run that hangs ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit is_blank(input logic [7:0] code);
        return (code >= 8'd9 && code <= 8'd13) || code == 8'd32;
    endfunction

    // Base-32 value of a character, upper case folded to lower; -1 when not a digit.
    function automatic int digit_of(input logic [7:0] code);
        logic [7:0] lc;
        lc = (code >= "A" && code <= "Z") ? code + 8'd32 : code;
        for (int i = 0; i < 32; i++) begin
            if (DIGIT_SET[i] == lc) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Clear the predictor as the block does after each text.
    task automatic clear_cell_state();
        lat_acc = '0;
        lon_acc = '0;
        seen_count = '0;
        bad_seen = 1'b0;
    endtask

    // Fold one accepted character into the predictor; on the last one, queue the cell.
    task automatic absorb_char(input logic [7:0] code, input bit last);
        int idx;
        int v;
        int nlat;
        int nlon;
        longint lat_h;
        longint lon_h;
        longint lat_lo;
        longint lon_lo;
        logic [63:0] lat_lo_bits;
        logic [63:0] lon_lo_bits;
        logic [63:0] lat_hi_bits;
        logic [63:0] lon_hi_bits;
        logic [63:0] lat_mid_bits;
        logic [63:0] lon_mid_bits;
        cell_t pred_word;
        if (!is_blank(code)) begin
            idx = int'(seen_count);
            if (seen_count < GSD_COUNT_SAT) begin
                seen_count++;
            end
            if (idx < GSD_MAX_LEN) begin
                v = digit_of(code);
                if (v < 0) begin
                    bad_seen = 1'b1;
                end else begin
                    // Bits go most significant first; even global bit index is longitude.
                    for (int k = 0; k < 5; k++) begin
                        if (((idx * 5 + k) % 2) == 0) begin
                            lon_acc = {lon_acc[28:0], v[4-k]};
                        end else begin
                            lat_acc = {lat_acc[28:0], v[4-k]};
                        end
                    end
                end
            end
        end
        if (last) begin
            pred_word = '{status: GSD_OK, default: '0};
            pred_word.count = seen_count;
            if (seen_count == 0 || seen_count > GSD_MAX_LEN) begin
                pred_word.status = GSD_BAD_LEN;
            end else if (bad_seen) begin
                pred_word.status = GSD_BAD_CHAR;
            end else begin
                pred_word.status = GSD_OK;
                nlon = (5 * seen_count + 1) / 2;
                nlat = (5 * seen_count) / 2;
                lat_h = (64'sd1 << 30) >>> nlat;
                lon_h = (64'sd1 << 31) >>> nlon;
                lat_lo = -(64'sd1 << 30) + longint'(lat_acc) * 2 * lat_h;
                lon_lo = -(64'sd1 << 31) + longint'(lon_acc) * 2 * lon_h;
                lat_lo_bits = lat_lo;
                lon_lo_bits = lon_lo;
                lat_hi_bits = lat_lo + 2 * lat_h;
                lon_hi_bits = lon_lo + 2 * lon_h;
                lat_mid_bits = lat_lo + lat_h;
                lon_mid_bits = lon_lo + lon_h;
                pred_word.lat_lo = lat_lo_bits[31:0];
                pred_word.lat_hi = lat_hi_bits[31:0];
                pred_word.lon_lo = lon_lo_bits[32:0];
                pred_word.lon_hi = lon_hi_bits[32:0];
                pred_word.lat_mid = lat_mid_bits[31:0];
                pred_word.lon_mid = lon_mid_bits[32:0];
                pred_word.lat_half = lat_h[30:0];
                pred_word.lon_half = lon_h[31:0];
            end
            pending_cells = {pending_cells, pred_word};
            clear_cell_state();
        end
    endtask

    // Offer one character word and wait until it is taken.
    task automatic send_char(input logic [7:0] code, input bit last);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= code;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        absorb_char(code, last);
        chars_sent++;
    endtask

    task automatic send_text(input text_t txt);
        foreach (txt[i]) begin
            send_char(txt[i], i == txt.size() - 1);
        end
    endtask

    function automatic text_t bytes_of(input string s);
        text_t q;
        for (int i = 0; i < s.len(); i++) begin
            q = {q, s[i]};
        end
        return q;
    endfunction

    function automatic logic [7:0] random_digit();
        logic [7:0] c;
        c = DIGIT_SET[$urandom_range(0, 31)];
        if (c >= "b" && $urandom_range(0, 1) == 1) begin
            c = c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] random_blank();
        logic [7:0] c;
        c = 8'($urandom_range(9, 14));
        return (c == 8'd14) ? 8'd32 : c;
    endfunction

    function automatic logic [7:0] random_invalid();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_blank(c) || digit_of(c) >= 0);
        return c;
    endfunction

    // Spread occasional whitespace through a digit string, sometimes on the last byte.
    function automatic text_t with_blanks(input text_t digits);
        text_t q;
        foreach (digits[i]) begin
            if ($urandom_range(0, 9) == 0) begin
                q = {q, random_blank()};
            end
            q = {q, digits[i]};
        end
        if ($urandom_range(0, 7) == 0) begin
            q = {q, random_blank()};
        end
        return q;
    endfunction

    // One random text: mostly well-formed, the rest bad characters, overlong,
    // empty or pure noise.
    task automatic random_text();
        text_t digits;
        text_t txt;
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 94 && kind >= 88) begin
            repeat ($urandom_range(1, 3)) txt = {txt, random_blank()};
        end else if (kind >= 94) begin
            repeat ($urandom_range(1, 14)) txt = {txt, 8'($urandom_range(0, 255))};
        end else begin
            len = (kind < 80) ? $urandom_range(1, GSD_MAX_LEN) : $urandom_range(13, 20);
            repeat (len) digits = {digits, random_digit()};
            if ((kind >= 68 && kind < 80) || (kind >= 80 && $urandom_range(0, 3) == 0)) begin
                digits[$urandom_range(0, len - 1)] = random_invalid();
            end
            txt = with_blanks(digits);
        end
        send_text(txt);
    endtask

    // Extremes, case folding, whitespace, empty text, bad characters and overlong text.
    task automatic test_directed();
        send_text(bytes_of("0"));
        send_text(bytes_of("zzzzzzzzzzzz"));
        send_text({bytes_of("Ez"), 8'd9, bytes_of("S42"), 8'd13});
        send_text({8'd11});
        send_text({8'd10, 8'd12, 8'd32});
        send_text(bytes_of("ba9"));
        send_text({8'h00});
        send_text({8'hFF, 8'd8, 8'd14, bytes_of("ILO")});
        send_text(bytes_of("i000000000000"));
        send_text(bytes_of("0123456789bcdefgh"));
        send_text(bytes_of("000000000000!"));
        send_text(bytes_of("qrstuvwxyz5W"));
        send_text(bytes_of("BCDEFGHJKMNP"));
    endtask

    // Receiver holds off for a long stretch while short texts keep coming.
    task automatic test_backpressure();
        text_t digits;
        sender_idle = 1'b0;
        hold_request = 1'b1;
        repeat (40) begin
            digits = {};
            repeat ($urandom_range(1, 3)) digits = {digits, random_digit()};
            send_text(digits);
        end
        sender_idle = 1'b1;
    endtask

    task automatic test_random_mix(input int target);
        while (chars_sent < target) begin
            random_text();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate(input int n_chars);
        int start;
        start = chars_sent;
        sender_idle = 1'b0;
        stall_enable = 1'b0;
        while (chars_sent - start < n_chars) begin
            random_text();
        end
    endtask

    // Receiver: random stall bursts, or one long hold-off on request.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall_enable && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each result word taken with the oldest pending cell.
    always @(posedge aclk) begin : result_check
        cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cells.size() == 0) begin
                report_mismatch("result word arrived with nothing pending");
            end else begin
                want = pending_cells.pop_front();
                check_field("status", 64'(m_status), 64'(want.status));
                check_field("digit_count", 64'(m_digit_count), 64'(want.count));
                check_field("lat_low", 64'(m_lat_low), 64'(want.lat_lo));
                check_field("lat_high", 64'(m_lat_high), 64'(want.lat_hi));
                check_field("lon_low", 64'(m_lon_low), 64'(want.lon_lo));
                check_field("lon_high", 64'(m_lon_high), 64'(want.lon_hi));
                check_field("lat_center", 64'(m_lat_center), 64'(want.lat_mid));
                check_field("lon_center", 64'(m_lon_center), 64'(want.lon_mid));
                check_field("lat_half_size", 64'(m_lat_half_size), 64'(want.lat_half));
                check_field("lon_half_size", 64'(m_lon_half_size), 64'(want.lon_half));
            end
        end
    end

    // Reset, then the tests in turn, then drain and judge.
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_char_code <= 8'd0;
        s_last_char <= 1'b0;
        mismatches = 0;
        chars_sent = 0;
        cycle_count = 0;
        sender_idle = 1'b1;
        stall_enable = 1'b1;
        hold_request = 1'b0;
        clear_cell_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_mix(1100);
        test_full_rate(150);

        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### geohash_stream_decoder.f
+incdir+rtl
rtl/gsd_pkg.sv
rtl/gsd_front.sv
rtl/gsd_queue.sv
rtl/gsd_back.sv
rtl/geohash_stream_decoder.sv
tb/sv/testbench.sv
